### rtl/ftpt_pkg.sv
package ftpt_pkg;

    localparam int DEFAULT_WINDOW      = 256;
    localparam int DEFAULT_SAMPLE_BITS = 40;

    // percentile as a fraction
    localparam logic [7:0] PCT_NUM = 8'd95;
    localparam logic [7:0] PCT_DEN = 8'd100;

    // cell operations
    localparam logic [2:0] CELL_HOLD    = 3'd0;
    localparam logic [2:0] CELL_SHIFT   = 3'd1;
    localparam logic [2:0] CELL_LOAD    = 3'd2;
    localparam logic [2:0] CELL_COUNT   = 3'd3;
    localparam logic [2:0] CELL_CLEAR   = 3'd4;
    localparam logic [2:0] CELL_RESOLVE = 3'd5;

    typedef struct packed {
        logic [2:0] op;
    } cell_cmd_t;

endpackage

### rtl/ftpt_cell.sv
module ftpt_cell
    import ftpt_pkg::*;
#(
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
    parameter int CW          = 9,
    parameter int IDX         = 0
)
(
    input  logic                   clk,
    input  cell_cmd_t              cmd,
    input  logic [CW-1:0]          fill,
    input  logic [CW-1:0]          rank,
    input  logic [SAMPLE_BITS-1:0] shift_in,
    input  logic [SAMPLE_BITS-1:0] ring_in,
    input  logic                   ring_in_valid,
    output logic [SAMPLE_BITS-1:0] sample,
    output logic [SAMPLE_BITS-1:0] circ,
    output logic                   circ_valid
);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] circ_reg;
    logic                   circ_valid_reg;
    logic [CW-1:0]          lt_reg;
    logic [CW-1:0]          le_reg;
    logic                   own_valid;
    logic                   hit;

    // newest sample sits in cell zero, so the first fill cells are live
    assign own_valid = (CW'(IDX) < fill);
    assign hit       = own_valid && (lt_reg <= rank) && (rank < le_reg);

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CELL_HOLD:
            begin
            end
            CELL_SHIFT:
            begin
                sample_reg <= shift_in;
            end
            CELL_LOAD:
            begin
                circ_reg       <= sample_reg;
                circ_valid_reg <= own_valid;
                lt_reg         <= '0;
                le_reg         <= '0;
            end
            CELL_COUNT:
            begin
                if (circ_valid_reg && own_valid)
                begin
                    if (circ_reg < sample_reg)
                        lt_reg <= lt_reg + 1'b1;
                    if (circ_reg <= sample_reg)
                        le_reg <= le_reg + 1'b1;
                end
                circ_reg       <= ring_in;
                circ_valid_reg <= ring_in_valid;
            end
            CELL_CLEAR:
            begin
                circ_valid_reg <= 1'b0;
            end
            CELL_RESOLVE:
            begin
                // selected value ripples toward the last cell
                if (ring_in_valid)
                begin
                    circ_reg       <= ring_in;
                    circ_valid_reg <= 1'b1;
                end
                else if (hit)
                begin
                    circ_reg       <= sample_reg;
                    circ_valid_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sample     = sample_reg;
    assign circ       = circ_reg;
    assign circ_valid = circ_valid_reg;

endmodule

### rtl/frame_time_percentile_tracker_core.sv
// sequence: an accepted transaction steps through the load, count, clear, resolve and out states
// input stalls until the result passes to the output register, longer while a held result blocks
//   that hand-off; the cell row makes one full rotation to rank
//   every sample, then a second pass shifts the pick out
// reset: asynchronous active low; clears totals, maximum, fill count, output and control;
//   sample cells hold no reset and are read only after being written
module frame_time_percentile_tracker_core
    import ftpt_pkg::*;
#(
    parameter int WINDOW      = DEFAULT_WINDOW,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [39:0] duration,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] running_total,
    output logic [39:0] running_max,
    output logic [8:0]  window_fill,
    output logic [39:0] percentile_95
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = (WINDOW > 2) ? $clog2(WINDOW) : 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD    = 3'd1;
    localparam logic [2:0] ST_COUNT   = 3'd2;
    localparam logic [2:0] ST_CLEAR   = 3'd3;
    localparam logic [2:0] ST_RESOLVE = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [SW-1:0]          step_reg, step_next;
    logic [63:0]            total_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [CW-1:0]          fill_reg;
    logic [CW-1:0]          rank_reg;
    logic [7:0]             rem_reg;

    logic                   res_valid_reg;
    logic [63:0]            res_total_reg;
    logic [39:0]            res_max_reg;
    logic [8:0]             res_fill_reg;
    logic [39:0]            res_pct_reg;

    logic                   in_take;
    logic                   out_take;
    logic                   res_load;
    logic                   step_last;
    logic [63:0]            dur_wide;
    logic [SAMPLE_BITS-1:0] dur_s;
    logic [7:0]             rem_sum;
    cell_cmd_t              cmd;

    logic [63:0]            max_wide;
    logic [63:0]            pct_wide;
    logic [15:0]            fill_wide;

    logic [SAMPLE_BITS-1:0] samp     [WINDOW];
    logic [SAMPLE_BITS-1:0] circ     [WINDOW];
    logic                   circ_v   [WINDOW];
    logic [SAMPLE_BITS-1:0] ring_in  [WINDOW];
    logic                   ring_v   [WINDOW];
    logic [SAMPLE_BITS-1:0] shift_in [WINDOW];

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = res_valid_reg;
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;
    assign res_load  = (state_reg == ST_OUT) && (!res_valid_reg || out_take);
    assign step_last = (step_reg == SW'(WINDOW - 1));

    assign dur_wide = 64'(duration);
    assign dur_s    = dur_wide[SAMPLE_BITS-1:0];
    assign rem_sum  = rem_reg + PCT_NUM;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_COUNT;
                step_next  = '0;
            end
            ST_COUNT:
            begin
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    state_next = ST_CLEAR;
                    step_next  = '0;
                end
            end
            ST_CLEAR:
            begin
                state_next = ST_RESOLVE;
                step_next  = '0;
            end
            ST_RESOLVE:
            begin
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    state_next = ST_OUT;
                    step_next  = '0;
                end
            end
            ST_OUT:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:    cmd.op = in_take ? CELL_SHIFT : CELL_HOLD;
            ST_LOAD:    cmd.op = CELL_LOAD;
            ST_COUNT:   cmd.op = CELL_COUNT;
            ST_CLEAR:   cmd.op = CELL_CLEAR;
            ST_RESOLVE: cmd.op = CELL_RESOLVE;
            default:    cmd.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            total_reg <= '0;
            max_reg   <= '0;
            fill_reg  <= '0;
            rank_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (in_take)
            begin
                total_reg <= total_reg + 64'(dur_s);
                if (dur_s > max_reg)
                    max_reg <= dur_s;
                // rank tracks floor(fill*95/100) one step at a time
                if (fill_reg != CW'(WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                    if (rem_sum >= PCT_DEN)
                    begin
                        rem_reg  <= rem_sum - PCT_DEN;
                        rank_reg <= rank_reg + 1'b1;
                    end
                    else
                    begin
                        rem_reg <= rem_sum;
                    end
                end
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                // ring closes during counting, chain is open while resolving
                assign shift_in[gi] = dur_s;
                assign ring_in[gi]  = circ[WINDOW-1];
                assign ring_v[gi]   = (state_reg == ST_COUNT) ? circ_v[WINDOW-1] : 1'b0;
            end
            else
            begin : g_body
                assign shift_in[gi] = samp[gi-1];
                assign ring_in[gi]  = circ[gi-1];
                assign ring_v[gi]   = circ_v[gi-1];
            end

            ftpt_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .CW          (CW),
                .IDX         (gi)
            ) u_cell (
                .clk           (clk),
                .cmd           (cmd),
                .fill          (fill_reg),
                .rank          (rank_reg),
                .shift_in      (shift_in[gi]),
                .ring_in       (ring_in[gi]),
                .ring_in_valid (ring_v[gi]),
                .sample        (samp[gi]),
                .circ          (circ[gi]),
                .circ_valid    (circ_v[gi])
            );
        end
    endgenerate

    assign max_wide  = 64'(max_reg);
    assign pct_wide  = 64'(circ[WINDOW-1]);
    assign fill_wide = 16'(fill_reg);

    // finished result waits here so the next transaction can start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_total_reg <= '0;
            res_max_reg   <= '0;
            res_fill_reg  <= '0;
            res_pct_reg   <= '0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
            res_total_reg <= total_reg;
            res_max_reg   <= max_wide[39:0];
            res_fill_reg  <= fill_wide[8:0];
            res_pct_reg   <= pct_wide[39:0];
        end
        else if (out_take)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign running_total = res_total_reg;
    assign running_max   = res_max_reg;
    assign window_fill   = res_fill_reg;
    assign percentile_95 = res_pct_reg;

endmodule
